[rtl/lav_pkg.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, fixed-point constants and the transfer payload types.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int CoordWidth = 32;
  localparam int AxisWidth = 32;
  localparam int CoordFrac = 16;
  localparam int AxisFrac = 30;

  localparam int ScaledWidth = 30;
  localparam int SquareWidth = 2 * ScaledWidth;
  localparam int SumWidth = 2 * ScaledWidth + 2;
  localparam int RootWidth = ScaledWidth + 1;
  localparam int NumWidth = 2 * ScaledWidth + 1;
  localparam int QuotWidth = ScaledWidth + 1;

  localparam int UpWidth = 63;
  localparam int ProdWidth = 2 * AxisWidth;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic signed [AxisWidth-1:0]  right_x;
    logic signed [AxisWidth-1:0]  right_z;
    logic signed [AxisWidth-1:0]  up_x;
    logic signed [AxisWidth-1:0]  up_y;
    logic signed [AxisWidth-1:0]  up_z;
    logic signed [AxisWidth-1:0]  look_x;
    logic signed [AxisWidth-1:0]  look_y;
    logic signed [AxisWidth-1:0]  look_z;
    logic signed [CoordWidth-1:0] trans_x;
    logic signed [CoordWidth-1:0] trans_y;
    logic signed [CoordWidth-1:0] trans_z;
  } out_t;

endpackage

[rtl/look_at_view_matrix_core.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix core
// Left-handed view basis and translation from a camera pose.
//
// An item is one camera position and view direction in signed Q16.16, taken
// on the input channel when in_valid_i and in_ready_o are both high. The
// result, holding the right, up and look axes in Q2.30 and the saturated
// Q16.16 translation, is offered on the output channel and leaves on a
// transfer with out_ready_i high.
// The path from the input transfer to out_valid_o is three normalizers of
// 69 stages each (a 31-stage square root and a 31-stage divider dominate),
// two cross-product stages and three translation stages.
// Throughput is one item per cycle. The whole pipeline advances together;
// when the output register holds a result that is not taken, every stage
// holds and in_ready_o is low, so nothing is dropped or duplicated.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lav_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lav_pkg::out_t out_data_o
);

  localparam int CW = lav_pkg::CoordWidth;
  localparam int AW = lav_pkg::AxisWidth;
  localparam int UW = lav_pkg::UpWidth;
  localparam int PW = lav_pkg::ProdWidth;
  localparam int PosWidth = 3 * CW;
  localparam int LookSide = PosWidth;
  localparam int RightSide = 3 * AW + PosWidth;
  localparam int UpSide = 5 * AW + PosWidth;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [2:0][CW-1:0] pos_in, dir_in;
  assign pos_in = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
  assign dir_in = {in_data_i.dir_z, in_data_i.dir_y, in_data_i.dir_x};

  // Look axis.
  logic                  lk_valid;
  logic [2:0][AW-1:0]    lk_vec;
  logic [LookSide-1:0]   lk_side;

  lav_norm #(
    .InWidth  (CW),
    .SideWidth(LookSide)
  ) u_norm_look (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i && in_ready_o),
    .vec_i  (dir_in),
    .side_i (pos_in),
    .valid_o(lk_valid),
    .vec_o  (lk_vec),
    .side_o (lk_side)
  );

  // Right axis from world up crossed with look.
  logic [2:0][AW-1:0]   rc_in;
  logic                 rt_valid;
  logic [2:0][AW-1:0]   rt_vec;
  logic [RightSide-1:0] rt_side;
  logic [2:0][AW-1:0]   rt_look;
  logic [PosWidth-1:0]  rt_pos;

  assign rc_in = {AW'(0) - lk_vec[0], AW'(0), lk_vec[2]};

  lav_norm #(
    .InWidth  (AW),
    .SideWidth(RightSide)
  ) u_norm_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(lk_valid),
    .vec_i  (rc_in),
    .side_i ({lk_vec, lk_side}),
    .valid_o(rt_valid),
    .vec_o  (rt_vec),
    .side_o (rt_side)
  );

  assign {rt_look, rt_pos} = rt_side;

  // Up direction as look crossed with right, over two stages.
  logic signed [PW-1:0] pa_d, pb_d, pc_d, pd_d;
  logic signed [PW-1:0] pa1_q, pb1_q, pc1_q, pd1_q;
  logic [2:0][AW-1:0]   look1_q, look2_q;
  logic [AW-1:0]        rx1_q, rz1_q, rx2_q, rz2_q;
  logic [PosWidth-1:0]  pos1_q, pos2_q;
  logic                 xp1_valid_q, xp2_valid_q;
  logic [2:0][UW-1:0]   uc_d, uc2_q;

  always_comb begin
    pa_d = $signed(rt_look[1]) * $signed(rt_vec[2]);
    pb_d = $signed(rt_look[2]) * $signed(rt_vec[0]);
    pc_d = $signed(rt_look[0]) * $signed(rt_vec[2]);
    pd_d = $signed(rt_look[1]) * $signed(rt_vec[0]);
  end

  always_comb begin
    logic signed [PW-1:0] diff;
    logic signed [PW-1:0] negd;
    diff = pb1_q - pc1_q;
    negd = -pd1_q;
    uc_d[0] = pa1_q[UW-1:0];
    uc_d[1] = diff[UW-1:0];
    uc_d[2] = negd[UW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xp1_valid_q <= 1'b0;
      xp2_valid_q <= 1'b0;
    end else if (en) begin
      xp1_valid_q <= rt_valid;
      xp2_valid_q <= xp1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa1_q   <= pa_d;
      pb1_q   <= pb_d;
      pc1_q   <= pc_d;
      pd1_q   <= pd_d;
      look1_q <= rt_look;
      rx1_q   <= rt_vec[0];
      rz1_q   <= rt_vec[2];
      pos1_q  <= rt_pos;
      uc2_q   <= uc_d;
      look2_q <= look1_q;
      rx2_q   <= rx1_q;
      rz2_q   <= rz1_q;
      pos2_q  <= pos1_q;
    end
  end

  // Up axis.
  logic                 up_valid;
  logic [2:0][AW-1:0]   up_vec;
  logic [UpSide-1:0]    up_side;
  logic [AW-1:0]        up_rx, up_rz;
  logic [2:0][AW-1:0]   up_look;
  logic [2:0][CW-1:0]   up_pos;

  lav_norm #(
    .InWidth  (UW),
    .SideWidth(UpSide)
  ) u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(xp2_valid_q),
    .vec_i  (uc2_q),
    .side_i ({rx2_q, rz2_q, look2_q, pos2_q}),
    .valid_o(up_valid),
    .vec_o  (up_vec),
    .side_o (up_side)
  );

  assign {up_rx, up_rz, up_look, up_pos} = up_side;

  logic [2:0][2:0][AW-1:0] axes;
  assign axes = {up_look, up_vec, {up_rz, AW'(0), up_rx}};

  lav_trans u_trans (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(up_valid),
    .axes_i (axes),
    .pos_i  (up_pos),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  localparam logic signed [AW-1:0] AxisOne = AW'(1) << lav_pkg::AxisFrac;

  a_look_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.look_x <= AxisOne && out_data_o.look_x >= -AxisOne &&
                     out_data_o.look_y <= AxisOne && out_data_o.look_y >= -AxisOne &&
                     out_data_o.look_z <= AxisOne && out_data_o.look_z >= -AxisOne))
    else $error("look axis component out of unit range");

  a_zero_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.look_x == '0 && out_data_o.look_y == '0 &&
     out_data_o.look_z == '0) |->
    (out_data_o.right_x == '0 && out_data_o.right_z == '0 &&
     out_data_o.up_x == '0 && out_data_o.up_y == '0 && out_data_o.up_z == '0 &&
     out_data_o.trans_x == '0 && out_data_o.trans_y == '0 && out_data_o.trans_z == '0))
    else $error("zero look axis with nonzero basis or translation");

  a_zero_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.right_x == '0 && out_data_o.right_z == '0) |->
    (out_data_o.up_x == '0 && out_data_o.up_y == '0 && out_data_o.up_z == '0))
    else $error("zero right axis with nonzero up axis");

  a_up_y_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.up_y >= 0)
    else $error("up axis points below the horizon");

endmodule

[rtl/lav_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of the sum of squares, one result bit per stage.
// ----------------------------------------------------------------------------
module lav_sqrt #(
  parameter int SideWidth = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [lav_pkg::SumWidth-1:0]   rad_i,
  input  logic [SideWidth-1:0]           side_i,
  output logic                           valid_o,
  output logic [lav_pkg::RootWidth-1:0]  root_o,
  output logic [SideWidth-1:0]           side_o
);

  localparam int SumW = lav_pkg::SumWidth;
  localparam int Steps = lav_pkg::RootWidth;

  logic                 valid_q [Steps];
  logic [SumW-1:0]      rem_q   [Steps];
  logic [SumW-1:0]      res_q   [Steps];
  logic [SideWidth-1:0] side_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [SumW-1:0] Bit = SumW'(1) << (2 * (Steps - 1 - k));
    logic                 v_in;
    logic [SumW-1:0]      rem_in;
    logic [SumW-1:0]      res_in;
    logic [SideWidth-1:0] s_in;
    logic [SumW-1:0]      trial;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = rad_i;
      assign res_in = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = res_q[Steps-1][Steps-1:0];
  assign side_o  = side_q[Steps-1];

endmodule

[rtl/lav_div.sv]
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division of three numerators by one shared divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_div #(
  parameter int SideWidth = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][lav_pkg::NumWidth-1:0]    num_i,
  input  logic [lav_pkg::RootWidth-1:0]        den_i,
  input  logic [SideWidth-1:0]                 side_i,
  output logic                                 valid_o,
  output logic [2:0][lav_pkg::QuotWidth-1:0]   quot_o,
  output logic [SideWidth-1:0]                 side_o
);

  localparam int NumW = lav_pkg::NumWidth;
  localparam int DenW = lav_pkg::RootWidth;
  localparam int Steps = lav_pkg::QuotWidth;

  logic                      valid_q [Steps];
  logic [2:0][NumW-1:0]      rem_q   [Steps];
  logic [2:0][Steps-1:0]     quo_q   [Steps];
  logic [DenW-1:0]           den_q   [Steps];
  logic [SideWidth-1:0]      side_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Pos = Steps - 1 - k;
    logic                  v_in;
    logic [2:0][NumW-1:0]  rem_in;
    logic [2:0][Steps-1:0] quo_in;
    logic [DenW-1:0]       den_in;
    logic [SideWidth-1:0]  s_in;
    logic [NumW-1:0]       dsh;
    logic [2:0][NumW-1:0]  rem_d;
    logic [2:0][Steps-1:0] quo_d;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign dsh = NumW'(den_in) << Pos;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (rem_in[j] >= dsh) begin
          rem_d[j] = rem_in[j] - dsh;
          quo_d[j] = quo_in[j] | (Steps'(1) << Pos);
        end else begin
          rem_d[j] = rem_in[j];
          quo_d[j] = quo_in[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign quot_o  = quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

[rtl/lav_norm.sv]
// ----------------------------------------------------------------------------
// Pipelined three-component normalizer
// Scales a vector so that its largest magnitude lands just below one,
// takes the length and divides each component by it into Q2.30.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int InWidth   = 32,
  parameter int SideWidth = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][InWidth-1:0]              vec_i,
  input  logic [SideWidth-1:0]                 side_i,
  output logic                                 valid_o,
  output logic [2:0][lav_pkg::AxisWidth-1:0]   vec_o,
  output logic [SideWidth-1:0]                 side_o
);

  localparam int BlWidth = $clog2(InWidth + 1);
  localparam int MW = lav_pkg::ScaledWidth;
  localparam int SqW = lav_pkg::SquareWidth;
  localparam int SumW = lav_pkg::SumWidth;
  localparam int NumW = lav_pkg::NumWidth;
  localparam int DenW = lav_pkg::RootWidth;
  localparam int QW = lav_pkg::QuotWidth;
  localparam int AW = lav_pkg::AxisWidth;
  localparam int ExtWidth = InWidth + MW;
  localparam int FlagWidth = 4 + SideWidth;
  localparam int CarryWidth = 3 * MW + FlagWidth;

  // Stage 1: magnitudes and the largest of them.
  logic [2:0][InWidth-1:0] mag_d, mag1_q;
  logic [InWidth-1:0]      max_d, max1_q;
  logic [2:0]              neg1_q;
  logic [SideWidth-1:0]    side1_q;
  logic                    valid1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][InWidth-1] ? (~vec_i[i] + InWidth'(1)) : vec_i[i];
    end
    max_d = mag_d[0];
    if (mag_d[1] > max_d) begin
      max_d = mag_d[1];
    end
    if (mag_d[2] > max_d) begin
      max_d = mag_d[2];
    end
  end

  // Stage 2: bit length of the largest magnitude.
  logic [BlWidth-1:0]      bl_d, bl2_q;
  logic [2:0][InWidth-1:0] mag2_q;
  logic [2:0]              neg2_q;
  logic                    zero2_q;
  logic [SideWidth-1:0]    side2_q;
  logic                    valid2_q;

  always_comb begin
    bl_d = '0;
    for (int b = 0; b < InWidth; b++) begin
      if (max1_q[b]) begin
        bl_d = BlWidth'(b + 1);
      end
    end
  end

  // Stage 3: common shift of all magnitudes.
  logic [2:0][MW-1:0]   m_d, m3_q;
  logic [2:0]           neg3_q;
  logic                 zero3_q;
  logic [SideWidth-1:0] side3_q;
  logic                 valid3_q;

  always_comb begin
    logic [ExtWidth-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext = ExtWidth'(mag2_q[i]);
      if (bl2_q > BlWidth'(MW)) begin
        ext = ext >> (bl2_q - BlWidth'(MW));
      end else begin
        ext = ext << (BlWidth'(MW) - bl2_q);
      end
      m_d[i] = ext[MW-1:0];
    end
  end

  // Stage 4: squares. Stage 5: sum of squares.
  logic [2:0][SqW-1:0]  sq4_q;
  logic [2:0][MW-1:0]   m4_q, m5_q;
  logic [2:0]           neg4_q, neg5_q;
  logic                 zero4_q, zero5_q;
  logic [SideWidth-1:0] side4_q, side5_q;
  logic                 valid4_q, valid5_q;
  logic [SumW-1:0]      sum5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
      valid5_q <= valid4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      max1_q  <= max_d;
      neg1_q  <= {vec_i[2][InWidth-1], vec_i[1][InWidth-1], vec_i[0][InWidth-1]};
      side1_q <= side_i;

      bl2_q   <= bl_d;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      zero2_q <= (max1_q == '0);
      side2_q <= side1_q;

      m3_q    <= m_d;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
      side3_q <= side2_q;

      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= SqW'(m3_q[i]) * SqW'(m3_q[i]);
      end
      m4_q    <= m3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
      side4_q <= side3_q;

      sum5_q  <= SumW'(sq4_q[0]) + SumW'(sq4_q[1]) + SumW'(sq4_q[2]);
      m5_q    <= m4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
      side5_q <= side4_q;
    end
  end

  logic                  sq_valid;
  logic [DenW-1:0]       sq_root;
  logic [CarryWidth-1:0] sq_side;

  lav_sqrt #(
    .SideWidth(CarryWidth)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(valid5_q),
    .rad_i  (sum5_q),
    .side_i ({m5_q, neg5_q, zero5_q, side5_q}),
    .valid_o(sq_valid),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Stage after the root: rounded numerators.
  logic [2:0][MW-1:0]   sq_m;
  logic [FlagWidth-1:0] sq_flags;
  logic [2:0][NumW-1:0] num_d, num6_q;
  logic [DenW-1:0]      den6_q;
  logic [FlagWidth-1:0] flags6_q;
  logic                 valid6_q;

  assign {sq_m, sq_flags} = sq_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = {1'b0, sq_m[i], MW'(0)} + NumW'(sq_root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid6_q <= 1'b0;
    end else if (en_i) begin
      valid6_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num6_q   <= num_d;
      den6_q   <= sq_root;
      flags6_q <= sq_flags;
    end
  end

  logic                 dv_valid;
  logic [2:0][QW-1:0]   dv_quot;
  logic [FlagWidth-1:0] dv_flags;

  lav_div #(
    .SideWidth(FlagWidth)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(valid6_q),
    .num_i  (num6_q),
    .den_i  (den6_q),
    .side_i (flags6_q),
    .valid_o(dv_valid),
    .quot_o (dv_quot),
    .side_o (dv_flags)
  );

  // Final stage: signs restored, zero vectors forced to zero.
  logic [2:0]           dv_neg;
  logic                 dv_zero;
  logic [SideWidth-1:0] dv_side;
  logic [2:0][AW-1:0]   vec_d, vec7_q;
  logic [SideWidth-1:0] side7_q;
  logic                 valid7_q;

  assign {dv_neg, dv_zero, dv_side} = dv_flags;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero) begin
        vec_d[i] = '0;
      end else if (dv_neg[i]) begin
        vec_d[i] = AW'(0) - AW'(dv_quot[i]);
      end else begin
        vec_d[i] = AW'(dv_quot[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid7_q <= 1'b0;
    end else if (en_i) begin
      valid7_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec7_q  <= vec_d;
      side7_q <= dv_side;
    end
  end

  assign valid_o = valid7_q;
  assign vec_o   = vec7_q;
  assign side_o  = side7_q;

endmodule

[rtl/lav_trans.sv]
// ----------------------------------------------------------------------------
// Translation and output register
// Rounds each axis-by-position product to Q16.16, sums, negates and
// saturates, and holds the finished result for the output transfer.
// ----------------------------------------------------------------------------
module lav_trans (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic [2:0][2:0][lav_pkg::AxisWidth-1:0]     axes_i,
  input  logic [2:0][lav_pkg::CoordWidth-1:0]         pos_i,
  output logic                                        valid_o,
  output lav_pkg::out_t                               data_o
);

  localparam int CW = lav_pkg::CoordWidth;
  localparam int AW = lav_pkg::AxisWidth;
  localparam int FracIn = lav_pkg::CoordFrac;
  localparam int RoundShift = lav_pkg::AxisFrac - lav_pkg::CoordFrac;
  localparam int PhWidth = CW - FracIn + 1;
  localparam int LoWidth = FracIn + 1;
  localparam int XW = PhWidth + AW;
  localparam int YW = LoWidth + AW;
  localparam int AccW = ((XW > YW) ? XW : YW) + 1;
  localparam int TW = CW + 4;
  localparam int SW = TW + 2;
  localparam logic [YW-1:0] Half = YW'(1) << (lav_pkg::AxisFrac - 1);

  // Stage 1: split products.
  logic [2:0][2:0][XW-1:0] x_d, x1_q;
  logic [2:0][2:0][YW-1:0] y_d, y1_q;
  logic [2:0][2:0][AW-1:0] axes1_q, axes2_q;
  logic                    valid1_q, valid2_q, valid3_q;

  always_comb begin
    logic signed [PhWidth-1:0] ph;
    logic signed [LoWidth-1:0] pl;
    logic signed [AW-1:0]      ax;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        ph = PhWidth'($signed(pos_i[c]) >>> FracIn);
        pl = $signed({1'b0, pos_i[c][FracIn-1:0]});
        ax = $signed(axes_i[a][c]);
        x_d[a][c] = ph * ax;
        y_d[a][c] = pl * ax;
      end
    end
  end

  // Stage 2: rounded Q16.16 terms.
  logic [2:0][2:0][TW-1:0] t_d, t2_q;

  always_comb begin
    logic signed [YW-1:0]   yr;
    logic signed [YW-1:0]   ysh;
    logic signed [AccW-1:0] acc;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        yr  = $signed(y1_q[a][c]) + $signed(Half);
        ysh = yr >>> FracIn;
        acc = AccW'($signed(x1_q[a][c])) + AccW'(ysh);
        acc = acc >>> RoundShift;
        t_d[a][c] = acc[TW-1:0];
      end
    end
  end

  // Stage 3: negated sums with saturation, into the output register.
  lav_pkg::out_t out_d, out_q;
  logic [2:0][CW-1:0] tr_d;

  always_comb begin
    logic [SW-1:0]    s;
    logic [SW-CW:0]   hi;
    for (int a = 0; a < 3; a++) begin
      s = SW'(0) - SW'($signed(t2_q[a][0])) - SW'($signed(t2_q[a][1]))
          - SW'($signed(t2_q[a][2]));
      hi = s[SW-1:CW-1];
      if ((&hi) || !(|hi)) begin
        tr_d[a] = s[CW-1:0];
      end else if (s[SW-1]) begin
        tr_d[a] = {1'b1, {(CW - 1){1'b0}}};
      end else begin
        tr_d[a] = {1'b0, {(CW - 1){1'b1}}};
      end
    end
    out_d.right_x = axes2_q[0][0];
    out_d.right_z = axes2_q[0][2];
    out_d.up_x    = axes2_q[1][0];
    out_d.up_y    = axes2_q[1][1];
    out_d.up_z    = axes2_q[1][2];
    out_d.look_x  = axes2_q[2][0];
    out_d.look_y  = axes2_q[2][1];
    out_d.look_z  = axes2_q[2][2];
    out_d.trans_x = tr_d[0];
    out_d.trans_y = tr_d[1];
    out_d.trans_z = tr_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x_d;
      y1_q    <= y_d;
      axes1_q <= axes_i;
      t2_q    <= t_d;
      axes2_q <= axes1_q;
      out_q   <= out_d;
    end
  end

  assign valid_o = valid3_q;
  assign data_o  = out_q;

endmodule

[dv/look_at_view_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix checker
// Watches both channels, computes the expected view basis and translation for
// every input transfer and compares each output transfer against the oldest.
// ----------------------------------------------------------------------------
module look_at_view_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  lav_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  lav_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  typedef logic signed [63:0] s64_t;
  typedef s64_t vec3_t [3];

  lav_pkg::out_t expected_views[$];
  int            fails;

  assign fail_count_o = fails;
  assign pending_o = expected_views.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v);
    logic [63:0] mag [3];
    logic [63:0] mx;
    logic [63:0] total;
    logic [63:0] len;
    logic [63:0] q;
    int          nbits;
    vec3_t       o;
    mx = 0;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return o;
    end
    nbits = 0;
    while (nbits < 64 && (mx >> nbits) != 0) nbits++;
    for (int i = 0; i < 3; i++) begin
      if (nbits > 30) mag[i] = mag[i] >> (nbits - 30);
      else if (nbits < 30) mag[i] = mag[i] << (30 - nbits);
      total = total + mag[i] * mag[i];
    end
    len = int_sqrt(total);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      o[i] = (v[i] < 0) ? -s64_t'(q) : s64_t'(q);
    end
    return o;
  endfunction

  function automatic s64_t scale_q30(s64_t a, s64_t p);
    s64_t lo;
    s64_t hi;
    s64_t y;
    lo = p & 64'hFFFF;
    hi = p >>> 16;
    y = lo * a + (s64_t'(1) << 29);
    return (hi * a + (y >>> 16)) >>> 14;
  endfunction

  function automatic logic [31:0] view_offset(vec3_t ax, vec3_t p);
    s64_t s;
    s = -(scale_q30(ax[0], p[0]) + scale_q30(ax[1], p[1]) + scale_q30(ax[2], p[2]));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic lav_pkg::out_t view_basis(lav_pkg::in_t item);
    vec3_t         pos, dir, lk, rc, rt, uc, up;
    lav_pkg::out_t r;
    pos[0] = item.pos_x; pos[1] = item.pos_y; pos[2] = item.pos_z;
    dir[0] = item.dir_x; dir[1] = item.dir_y; dir[2] = item.dir_z;
    lk = unit_vec(dir);
    rc[0] = lk[2]; rc[1] = 0; rc[2] = -lk[0];
    rt = unit_vec(rc);
    uc[0] = lk[1] * rt[2] - lk[2] * rt[1];
    uc[1] = lk[2] * rt[0] - lk[0] * rt[2];
    uc[2] = lk[0] * rt[1] - lk[1] * rt[0];
    up = unit_vec(uc);
    r.right_x = rt[0][31:0];
    r.right_z = rt[2][31:0];
    r.up_x = up[0][31:0];
    r.up_y = up[1][31:0];
    r.up_z = up[2][31:0];
    r.look_x = lk[0][31:0];
    r.look_y = lk[1][31:0];
    r.look_z = lk[2][31:0];
    r.trans_x = view_offset(rt, pos);
    r.trans_y = view_offset(up, pos);
    r.trans_z = view_offset(lk, pos);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    lav_pkg::out_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) expected_views.push_back(view_basis(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_views.size() == 0) begin
          $error("output transfer with no result expected");
          fails++;
        end else begin
          e = expected_views.pop_front();
          check_field("right_x", e.right_x, out_data_i.right_x);
          check_field("right_z", e.right_z, out_data_i.right_z);
          check_field("up_x", e.up_x, out_data_i.up_x);
          check_field("up_y", e.up_y, out_data_i.up_y);
          check_field("up_z", e.up_z, out_data_i.up_z);
          check_field("look_x", e.look_x, out_data_i.look_x);
          check_field("look_y", e.look_y, out_data_i.look_y);
          check_field("look_z", e.look_z, out_data_i.look_z);
          check_field("trans_x", e.trans_x, out_data_i.trans_x);
          check_field("trans_y", e.trans_y, out_data_i.trans_y);
          check_field("trans_z", e.trans_z, out_data_i.trans_z);
        end
      end
    end
  end

endmodule

[dv/tb_look_at_view_matrix_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix core testbench
// Drives directed and random camera poses with random idling on both channels
// and a long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix_core;

  localparam int NumRandom = 730;
  localparam int Latency = 212;

  logic          clk, rst_n;
  logic          in_valid, in_ready, out_valid, out_ready;
  lav_pkg::in_t  in_data;
  lav_pkg::out_t out_data;
  int            fail_count, pending;
  bit            calm;
  bit            hold_out;

  look_at_view_matrix_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  look_at_view_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("look_at_view_matrix_core regression: fail");
    $finish;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 131071) - 65536;
      4: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pose(logic [31:0] px, py, pz, dx, dy, dz);
    in_data <= {px, py, pz, dx, dy, dz};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Output side: random stalls, a long hold-off on request, none when calm.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] c [6];
    int wait_cycles;
    calm = 0;
    hold_out = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pose(0, 0, 0, 0, 0, 0);
    send_pose(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 32'h0001_0000);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0001_0000, 0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_0000, 0);
    send_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_pose(1, 32'hFFFF_FFFF, 1, 1, 0, 0);
    send_pose(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
    send_pose(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1, 32'h7FFF_FFFF, 1);
    send_pose(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pose(32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    hold_out = 1'b1;
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 120) calm = 1;
      for (int k = 0; k < 6; k++) c[k] = pick_coord();
      if ($urandom_range(0, 9) == 0) begin
        c[3] = 0;
        c[5] = 0;
      end
      send_pose(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (Latency + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("look_at_view_matrix_core regression: pass");
    end else begin
      $display("look_at_view_matrix_core regression: fail");
    end
    $finish;
  end

endmodule
